[src/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define VPTW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define VPTW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/vptw_pkg.sv]
// shared types, codes and helpers for the vertex projection block
package vptw_pkg;

  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 8'd3;

  localparam logic [14:0] VIEW_SIZE_RESET = 15'd400;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_PROJECT = 1'b1;

  localparam logic STAGE_MODELVIEW  = 1'b0;
  localparam logic STAGE_PROJECTION = 1'b1;

  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;
  localparam logic [1:0] SEL_Z = 2'd2;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic       ram_we;
    logic       capture;
    logic       issue;
    logic       stage;
    logic [1:0] row;
    logic [1:0] col;
    logic       fail;
    logic       num_load;
    logic       div_start;
    logic       div_take;
    logic [1:0] sel;
    logic       out_load;
  } vptw_cmd_t;

  typedef struct packed {
    logic cw_zero;
    logic div_done;
  } vptw_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7fffffff;
    else if (v < S32_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[src/vptw_if.sv]
// channel interfaces: point/load items, results, configuration writes
interface vptw_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [4:0]         element_index;
  logic signed [31:0] element_value;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  modport source (output valid, mode, element_index, element_value,
                  point_x, point_y, point_z, input ready);
  modport sink   (input valid, mode, element_index, element_value,
                  point_x, point_y, point_z, output ready);
endinterface

interface vptw_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] window_x;
  logic signed [31:0] window_y;
  logic signed [31:0] window_depth;
  logic               projected_ok;

  modport source (output valid, window_x, window_y, window_depth, projected_ok,
                  input ready);
  modport sink   (input valid, window_x, window_y, window_depth, projected_ok,
                  output ready);
endinterface

interface vptw_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [vptw_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/vptw_ram.sv]
// generic single-write, single-read ram with registered read data
module vptw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/vptw_div.sv]
// radix-2 restoring divider, truncating signed quotient, one bit per cycle
module vptw_div #(
  parameter int NUM_W = 49
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [32:0]      den,
  output logic                    done,
  output logic signed [NUM_W:0]   quo,
  output logic                    rem_nz,
  output logic                    neg
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] dvd_r;
  logic [32:0]      dsr_r;
  logic [32:0]      rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             neg_r;

  logic [33:0] rem_sh;
  logic [34:0] diff;
  logic        ge;

  assign rem_sh = {rem_r, dvd_r[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr_r};
  assign ge     = !diff[34];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(NUM_W);
      neg_r  <= num[NUM_W-1] ^ den[32];
      dvd_r  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      dsr_r  <= den[32] ? 33'(-den) : 33'(den);
      rem_r  <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[32:0] : rem_sh[32:0];
      dvd_r <= {dvd_r[NUM_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done   = done_r;
  assign quo    = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});
  assign rem_nz = |rem_r;
  assign neg    = neg_r;

endmodule

[src/vptw_ctrl.sv]
// sequencer: matrix pass issue, drains, divide steps and result hand-off
module vptw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_mode,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  vptw_pkg::vptw_sts_t sts,
  output vptw_pkg::vptw_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_MV, S_DR1, S_PR, S_DR2, S_CHK, S_NUM, S_DST, S_DWT, S_OUT
  } state_t;

  state_t     state_r;
  logic [3:0] cnt_r;
  logic [1:0] dcnt_r;
  logic [1:0] sel_r;
  logic       out_valid_r;

  logic accept;
  logic out_free;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.ram_we    = accept && (in_mode == vptw_pkg::MODE_LOAD);
    cmd.capture   = accept && (in_mode == vptw_pkg::MODE_PROJECT);
    cmd.issue     = (state_r == S_MV) || (state_r == S_PR);
    cmd.stage     = (state_r == S_PR) ? vptw_pkg::STAGE_PROJECTION
                                      : vptw_pkg::STAGE_MODELVIEW;
    cmd.row       = cnt_r[3:2];
    cmd.col       = cnt_r[1:0];
    cmd.fail      = (state_r == S_CHK) && sts.cw_zero;
    cmd.num_load  = (state_r == S_NUM);
    cmd.div_start = (state_r == S_DST);
    cmd.div_take  = (state_r == S_DWT) && sts.div_done;
    cmd.sel       = sel_r;
    cmd.out_load  = (state_r == S_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      dcnt_r      <= '0;
      sel_r       <= vptw_pkg::SEL_X;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_mode == vptw_pkg::MODE_PROJECT)) begin
            state_r <= S_MV;
            cnt_r   <= '0;
          end
        end
        S_MV, S_PR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 4'd15) begin
            dcnt_r  <= '0;
            state_r <= (state_r == S_MV) ? S_DR1 : S_DR2;
          end
        end
        S_DR1: begin
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == 2'd2) begin
            state_r <= S_PR;
            cnt_r   <= '0;
          end
        end
        S_DR2: begin
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == 2'd2) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          sel_r <= vptw_pkg::SEL_X;
          if (sts.cw_zero) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_NUM;
          end
        end
        S_NUM: state_r <= S_DST;
        S_DST: state_r <= S_DWT;
        S_DWT: begin
          if (sts.div_done) begin
            if (sel_r == vptw_pkg::SEL_Z) begin
              state_r <= S_OUT;
            end else begin
              sel_r   <= sel_r + 1'b1;
              state_r <= S_NUM;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

[src/vptw_dp.sv]
// datapath: matrix store, shared multiply-accumulate, divide and window mapping
module vptw_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  vptw_pkg::vptw_cmd_t                  cmd,
  output vptw_pkg::vptw_sts_t                  sts,
  input  logic [4:0]                           element_index,
  input  logic signed [31:0]                   element_value,
  input  logic signed [31:0]                   point_x,
  input  logic signed [31:0]                   point_y,
  input  logic signed [31:0]                   point_z,
  input  logic                                 cfg_we,
  input  logic [vptw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_data,
  output logic signed [31:0]                   window_x,
  output logic signed [31:0]                   window_y,
  output logic signed [31:0]                   window_depth,
  output logic                                 projected_ok
);

  localparam int ACC_W = 66 - FRAC_BITS;
  localparam int NUM_W = (33 + FRAC_BITS > 49) ? 33 + FRAC_BITS : 49;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  // viewport registers
  logic [13:0] org_x_r, org_y_r;
  logic [14:0] size_x_r, size_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r  <= '0;
      org_y_r  <= '0;
      size_x_r <= vptw_pkg::VIEW_SIZE_RESET;
      size_y_r <= vptw_pkg::VIEW_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vptw_pkg::CFG_ORIGIN_X: org_x_r  <= cfg_data[13:0];
        vptw_pkg::CFG_ORIGIN_Y: org_y_r  <= cfg_data[13:0];
        vptw_pkg::CFG_WIDTH:    size_x_r <= cfg_data[14:0];
        vptw_pkg::CFG_HEIGHT:   size_y_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // matrix store
  logic [4:0]  raddr;
  logic [31:0] rdata;

  assign raddr = {cmd.stage, cmd.col, cmd.row};

  vptw_ram #(.WIDTH(32), .DEPTH(32)) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (element_index),
    .wdata (element_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // multiply-accumulate pipeline: read, multiply, accumulate
  logic signed [31:0] px_r, py_r, pz_r;
  logic signed [31:0] eye_r  [4];
  logic signed [31:0] clip_r [4];

  logic       v1_r, v2_r;
  logic       st1_r, st2_r;
  logic [1:0] row1_r, row2_r, col1_r, col2_r;

  logic signed [31:0]    opnd;
  logic signed [63:0]    prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [63:0]    prod_sh;

  always_comb begin
    if (st1_r == vptw_pkg::STAGE_MODELVIEW) begin
      unique case (col1_r)
        2'd0: opnd = px_r;
        2'd1: opnd = py_r;
        2'd2: opnd = pz_r;
        default: opnd = ONE;
      endcase
    end else begin
      opnd = eye_r[col1_r];
    end
  end

  assign prod_sh = prod_r >>> FRAC_BITS;
  assign acc_nxt = ((col2_r == 2'd0) ? ACC_W'(0) : acc_r) + ACC_W'(prod_sh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
    st1_r  <= cmd.stage;
    row1_r <= cmd.row;
    col1_r <= cmd.col;
    st2_r  <= st1_r;
    row2_r <= row1_r;
    col2_r <= col1_r;
    prod_r <= $signed(rdata) * opnd;
    if (cmd.capture) begin
      px_r <= point_x;
      py_r <= point_y;
      pz_r <= point_z;
    end
    if (v2_r) begin
      acc_r <= acc_nxt;
      if (col2_r == 2'd3) begin
        if (st2_r == vptw_pkg::STAGE_MODELVIEW) begin
          eye_r[row2_r] <= vptw_pkg::sat32(64'(acc_nxt));
        end else begin
          clip_r[row2_r] <= vptw_pkg::sat32(64'(acc_nxt));
        end
      end
    end
  end

  assign sts.cw_zero = (clip_r[3] == 32'sd0);

  // numerator for the selected coordinate
  logic signed [32:0]      sum_c;
  logic signed [15:0]      size_s;
  logic signed [NUM_W-1:0] num_nxt, num_r;
  logic signed [32:0]      den;

  always_comb begin
    unique case (cmd.sel)
      vptw_pkg::SEL_X: begin
        sum_c  = 33'(clip_r[3]) + 33'(clip_r[0]);
        size_s = $signed({1'b0, size_x_r});
      end
      vptw_pkg::SEL_Y: begin
        sum_c  = 33'(clip_r[3]) + 33'(clip_r[1]);
        size_s = $signed({1'b0, size_y_r});
      end
      default: begin
        sum_c  = 33'(clip_r[3]) + 33'(clip_r[2]);
        size_s = 16'sd0;
      end
    endcase
    if (cmd.sel == vptw_pkg::SEL_Z) begin
      num_nxt = NUM_W'(sum_c) <<< FRAC_BITS;
    end else begin
      num_nxt = NUM_W'(sum_c * size_s);
    end
  end

  assign den = $signed({clip_r[3], 1'b0});

  always_ff @(posedge clk) begin
    if (cmd.num_load) begin
      num_r <= num_nxt;
    end
  end

  logic                  div_done;
  logic signed [NUM_W:0] quo;
  logic                  rem_nz;
  logic                  qneg;

  vptw_div #(.NUM_W(NUM_W)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.div_start),
    .num    (num_r),
    .den    (den),
    .done   (div_done),
    .quo    (quo),
    .rem_nz (rem_nz),
    .neg    (qneg)
  );

  assign sts.div_done = div_done;

  // window mapping: floor first, ceiling when the floored sum is negative
  logic signed [63:0] q64, qfl, qce, org64, fl, wres;

  always_comb begin
    q64   = 64'(quo);
    qfl   = q64 - ((rem_nz && qneg) ? 64'sd1 : 64'sd0);
    qce   = q64 + ((rem_nz && !qneg) ? 64'sd1 : 64'sd0);
    org64 = (cmd.sel == vptw_pkg::SEL_X) ? $signed({50'd0, org_x_r})
                                         : $signed({50'd0, org_y_r});
    fl    = org64 + qfl;
    wres  = (fl >= 64'sd0) ? fl : (org64 + qce);
  end

  logic signed [31:0] rx_r, ry_r, rz_r;
  logic               rok_r;
  logic signed [31:0] wx_r, wy_r, wz_r;
  logic               ok_r;

  always_ff @(posedge clk) begin
    if (cmd.fail) begin
      rx_r  <= '0;
      ry_r  <= '0;
      rz_r  <= '0;
      rok_r <= 1'b0;
    end else if (cmd.div_take) begin
      unique case (cmd.sel)
        vptw_pkg::SEL_X: rx_r <= vptw_pkg::sat32(wres);
        vptw_pkg::SEL_Y: ry_r <= vptw_pkg::sat32(wres);
        default: begin
          rz_r  <= vptw_pkg::sat32(q64);
          rok_r <= 1'b1;
        end
      endcase
    end
    if (cmd.out_load) begin
      wx_r <= rx_r;
      wy_r <= ry_r;
      wz_r <= rz_r;
      ok_r <= rok_r;
    end
  end

  assign window_x     = wx_r;
  assign window_y     = wy_r;
  assign window_depth = wz_r;
  assign projected_ok = ok_r;

endmodule

[src/vertex_project_to_window.sv]
// top level of the vertex projection block
//
//  port    | dir | handshake   | payload
//  in_ch   | in  | valid/ready | mode, element_index, element_value, point_x/y/z
//  out_ch  | out | valid/ready | window_x, window_y, window_depth, projected_ok
//  cfg_ch  | in  | valid/ready | index, data (viewport origin and size)
//
// a load item is written to the matrix store on accept, leaving the block idle; a
// project item takes 32 matrix products on one shared multiplier, with read and
// drain gaps and then the w check, and three bit-serial divides when clip w is
// nonzero; when clip w is zero the result is a failed projection with no divides
// a finished result waits in the output register while the next item is
// accepted; a stalled output holds only the next result hand-off; reset is
// synchronous, rst_n low
module vertex_project_to_window #(
  parameter int FRAC_BITS = 16
) (
  input logic          clk,
  input logic          rst_n,
  vptw_in_if.sink      in_ch,
  vptw_out_if.source   out_ch,
  vptw_cfg_if.sink     cfg_ch
);

  vptw_pkg::vptw_cmd_t cmd;
  vptw_pkg::vptw_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  vptw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vptw_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .element_index (in_ch.element_index),
    .element_value (in_ch.element_value),
    .point_x       (in_ch.point_x),
    .point_y       (in_ch.point_y),
    .point_z       (in_ch.point_z),
    .cfg_we        (cfg_ch.valid),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .window_x      (out_ch.window_x),
    .window_y      (out_ch.window_y),
    .window_depth  (out_ch.window_depth),
    .projected_ok  (out_ch.projected_ok)
  );

endmodule

[src/vptw_checker.sv]
// port-level checks for the vertex projection block, bound to the top level
`include "assert_macros.svh"

module vptw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_mode,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] window_x,
  input logic signed [31:0] window_y,
  input logic signed [31:0] window_depth,
  input logic               projected_ok
);

  // a stalled result item holds its valid, window_x and window_depth
  `VPTW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(window_x) && $stable(window_depth), "result changed while stalled")

  // a failed projection carries zero coordinates
  `VPTW_ASSERT(a_fail_zero, out_valid && !projected_ok |-> window_x == 32'sd0 && window_y == 32'sd0 && window_depth == 32'sd0, "failed projection with nonzero fields")

  // a load item never produces a result
  `VPTW_ASSERT(a_load_quiet, in_valid && in_ready && in_mode == vptw_pkg::MODE_LOAD && !out_valid |=> !out_valid, "result after load item")

  // reset empties the output
  `VPTW_ASSERT_ALWAYS(a_reset_out, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind vertex_project_to_window vptw_checker u_vptw_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_mode      (in_ch.mode),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .window_x     (out_ch.window_x),
  .window_y     (out_ch.window_y),
  .window_depth (out_ch.window_depth),
  .projected_ok (out_ch.projected_ok)
);
